// ----- rtl/core/btpl_pkg.sv -----
// shared types, codes and constants of the binary trie prefix lookup block
package btpl_pkg;

    localparam int IDX_W       = 18;
    localparam int COUNT_W     = 19;
    localparam int NET_W       = 32;
    localparam int NET_IDX_W   = 31;
    localparam int ADDR_W      = 128;
    localparam int V4_W        = 32;
    localparam int POS_W       = 8;
    localparam int IDX_EXT_W   = 25;
    localparam int CFG_DATA_W  = 19;
    localparam int CFG_IDX_W   = 1;
    localparam int NODE_ENTRIES_DEF = 262144;

    localparam logic [POS_W-1:0] V6_BITS = POS_W'(ADDR_W);
    localparam logic [POS_W-1:0] V4_BITS = POS_W'(V4_W);

    localparam logic [NET_W-1:0] NO_NET  = 32'hFFFF_FFFF;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_V4    = 2'd1;
    localparam logic [1:0] CMD_V6    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IPV4_ROOT  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        command;
        logic [IDX_W-1:0]  node_index;
        logic [IDX_W-1:0]  child_zero;
        logic [IDX_W-1:0]  child_one;
        logic [NET_W-1:0]  network_word;
        logic [63:0]       address_high;
        logic [63:0]       address_low;
    } t_in_word;

    typedef struct packed {
        logic                 found;
        logic [NET_IDX_W-1:0] network_index;
        logic                 range_fault;
    } t_out_word;

    typedef struct packed {
        logic [IDX_W-1:0] child_one;
        logic [IDX_W-1:0] child_zero;
        logic [NET_W-1:0] network;
    } t_node;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_done;

endpackage

// ----- rtl/core/btpl_node_mem.sv -----
// trie node memory: one write port, one read port with registered read data
module btpl_node_mem #(
    parameter int NODE_ENTRIES = btpl_pkg::NODE_ENTRIES_DEF,
    parameter int AW           = $clog2(NODE_ENTRIES)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  btpl_pkg::t_node i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output btpl_pkg::t_node o_rdata
);

    btpl_pkg::t_node r_mem [NODE_ENTRIES];
    btpl_pkg::t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/btpl_walker.sv -----
// command decode and trie walk sequencer over the node memory
module btpl_walker #(
    parameter int NODE_ENTRIES = btpl_pkg::NODE_ENTRIES_DEF,
    parameter int AW           = $clog2(NODE_ENTRIES)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  btpl_pkg::t_in_word              i_in_word,
    input  logic [btpl_pkg::COUNT_W-1:0]    i_node_count,
    input  logic [btpl_pkg::IDX_W-1:0]      i_ipv4_root,
    output logic                            o_mem_we,
    output logic [AW-1:0]                   o_mem_waddr,
    output btpl_pkg::t_node                 o_mem_wdata,
    output logic                            o_mem_re,
    output logic [AW-1:0]                   o_mem_raddr,
    input  btpl_pkg::t_node                 i_mem_rdata,
    output btpl_pkg::t_done                 o_done,
    input  logic                            i_taken
);

    localparam logic [btpl_pkg::IDX_EXT_W-1:0] ENTRIES_EXT =
        btpl_pkg::IDX_EXT_W'(NODE_ENTRIES);

    btpl_pkg::t_state               r_state, n_state;
    logic [btpl_pkg::IDX_W-1:0]     r_node;
    logic [btpl_pkg::POS_W-1:0]     r_pos;
    logic [btpl_pkg::NET_W-1:0]     r_best;
    logic [btpl_pkg::ADDR_W-1:0]    r_addr;
    logic                           r_v6;
    logic                           r_fault;

    logic                           accept;
    logic                           is_lookup;
    logic                           node_fault;
    logic                           last_bit;
    logic [btpl_pkg::NET_W-1:0]     best_now;
    logic [btpl_pkg::IDX_W-1:0]     child;
    logic                           child_zero_end;
    logic                           child_fault;
    logic                           go_on;

    function automatic logic out_of_range(
        input logic [btpl_pkg::IDX_W-1:0]   idx,
        input logic [btpl_pkg::COUNT_W-1:0] count
    );
        return (btpl_pkg::COUNT_W'(idx) >= count) ||
               (btpl_pkg::IDX_EXT_W'(idx) >= ENTRIES_EXT);
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [btpl_pkg::IDX_W-1:0] idx);
        logic [btpl_pkg::IDX_EXT_W-1:0] ext;
        ext = btpl_pkg::IDX_EXT_W'(idx);
        return ext[AW-1:0];
    endfunction

    assign accept    = i_in_valid && (r_state == btpl_pkg::ST_IDLE);
    assign is_lookup = (i_in_word.command == btpl_pkg::CMD_V4) ||
                       (i_in_word.command == btpl_pkg::CMD_V6);

    assign node_fault = out_of_range(r_node, i_node_count);

    // walk step on the node word that just came out of memory
    assign best_now       = i_mem_rdata.network[btpl_pkg::NET_W-1] ? r_best
                                                                   : i_mem_rdata.network;
    assign last_bit       = r_v6 ? (r_pos == btpl_pkg::V6_BITS)
                                 : (r_pos == btpl_pkg::V4_BITS);
    assign child          = r_addr[btpl_pkg::ADDR_W-1] ? i_mem_rdata.child_one
                                                       : i_mem_rdata.child_zero;
    assign child_zero_end = (child == '0);
    assign child_fault    = out_of_range(child, i_node_count);
    assign go_on          = !last_bit && !child_zero_end;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            btpl_pkg::ST_IDLE: begin
                if (accept && is_lookup) begin
                    n_state = btpl_pkg::ST_START;
                end
            end
            btpl_pkg::ST_START: begin
                n_state = node_fault ? btpl_pkg::ST_DONE : btpl_pkg::ST_WALK;
            end
            btpl_pkg::ST_WALK: begin
                if (!go_on || child_fault) begin
                    n_state = btpl_pkg::ST_DONE;
                end
            end
            btpl_pkg::ST_DONE: begin
                if (i_taken) begin
                    n_state = btpl_pkg::ST_IDLE;
                end
            end
            default: n_state = btpl_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != btpl_pkg::ST_IDLE);
        o_mem_we    = accept && (i_in_word.command == btpl_pkg::CMD_WRITE) &&
                      (btpl_pkg::IDX_EXT_W'(i_in_word.node_index) < ENTRIES_EXT);
        o_mem_waddr = to_addr(i_in_word.node_index);
        o_mem_wdata = '{child_one:  i_in_word.child_one,
                        child_zero: i_in_word.child_zero,
                        network:    i_in_word.network_word};
        o_mem_re    = 1'b0;
        o_mem_raddr = to_addr(r_node);
        unique case (r_state)
            btpl_pkg::ST_START: begin
                o_mem_re = !node_fault;
            end
            btpl_pkg::ST_WALK: begin
                o_mem_re    = go_on && !child_fault;
                o_mem_raddr = to_addr(child);
            end
            default: o_mem_re = 1'b0;
        endcase
        o_done.valid              = (r_state == btpl_pkg::ST_DONE);
        o_done.word.range_fault   = r_fault;
        o_done.word.found         = !r_fault && !r_best[btpl_pkg::NET_W-1];
        o_done.word.network_index = o_done.word.found ?
                                    r_best[btpl_pkg::NET_IDX_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btpl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            btpl_pkg::ST_IDLE: begin
                if (accept && is_lookup) begin
                    r_v6    <= (i_in_word.command == btpl_pkg::CMD_V6);
                    r_node  <= (i_in_word.command == btpl_pkg::CMD_V6) ? '0 : i_ipv4_root;
                    r_pos   <= '0;
                    r_best  <= btpl_pkg::NO_NET;
                    r_fault <= 1'b0;
                    r_addr  <= (i_in_word.command == btpl_pkg::CMD_V6) ?
                               {i_in_word.address_high, i_in_word.address_low} :
                               {i_in_word.address_low[btpl_pkg::V4_W-1:0],
                                {(btpl_pkg::ADDR_W-btpl_pkg::V4_W){1'b0}}};
                end
            end
            btpl_pkg::ST_START: begin
                if (node_fault) begin
                    r_fault <= 1'b1;
                end
            end
            btpl_pkg::ST_WALK: begin
                r_best <= best_now;
                if (go_on) begin
                    if (child_fault) begin
                        r_fault <= 1'b1;
                    end else begin
                        r_node <= child;
                        r_pos  <= r_pos + 1'b1;
                        r_addr <= {r_addr[btpl_pkg::ADDR_W-2:0], 1'b0};
                    end
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    a_fault_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done.valid && o_done.word.range_fault |-> !o_done.word.found)
        else $error("fault result reports a match");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == btpl_pkg::ST_WALK) |->
            (r_v6 ? (r_pos <= btpl_pkg::V6_BITS) : (r_pos <= btpl_pkg::V4_BITS)))
        else $error("walk ran past the last address bit");

    a_lookup_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_lookup |=> (r_state == btpl_pkg::ST_START))
        else $error("accepted lookup did not start a walk");

    a_read_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_re |=> (r_state == btpl_pkg::ST_WALK))
        else $error("node read issued with no walk step to consume it");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == btpl_pkg::ST_IDLE))
        else $error("node write while a lookup is in flight");
`endif

endmodule

// ----- rtl/core/binary_trie_prefix_lookup_top.sv -----
// top level: configuration registers, walker, node memory and result register
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall | i_in_word  (btpl_pkg::t_in_word)
//  out     | output    | o_out_valid/ i_out_stall| o_out_word (btpl_pkg::t_out_word)
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// a node write goes into the node memory when it is accepted; a lookup reads n nodes
// (at most 129 for ipv6, 33 for ipv4), set by one node memory read per address bit
// one item at a time: o_in_stall is high from acceptance of a lookup until its word
// moves into the result register, which holds it while i_out_stall is high
// reset is synchronous active low; the node memory is not cleared
module binary_trie_prefix_lookup_top #(
    parameter int NODE_ENTRIES = btpl_pkg::NODE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  btpl_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output btpl_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_we,
    input  logic [btpl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [btpl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(NODE_ENTRIES);

    logic [btpl_pkg::COUNT_W-1:0] r_node_count;
    logic [btpl_pkg::IDX_W-1:0]   r_ipv4_root;
    logic                         r_out_valid, n_out_valid;
    btpl_pkg::t_out_word          r_out_word;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    btpl_pkg::t_node              mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    btpl_pkg::t_node              mem_rdata;
    btpl_pkg::t_done              done;
    logic                         taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_ipv4_root  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                btpl_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data[btpl_pkg::COUNT_W-1:0];
                btpl_pkg::CFG_IPV4_ROOT:  r_ipv4_root  <= i_cfg_data[btpl_pkg::IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    btpl_walker #(
        .NODE_ENTRIES (NODE_ENTRIES),
        .AW           (AW)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_node_count (r_node_count),
        .i_ipv4_root  (r_ipv4_root),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_done       (done),
        .i_taken      (taken)
    );

    btpl_node_mem #(
        .NODE_ENTRIES (NODE_ENTRIES),
        .AW           (AW)
    ) u_node_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // result register takes a new word when empty or being drained
    assign taken       = done.valid && (!r_out_valid || !i_out_stall);
    assign n_out_valid = taken || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (taken) begin
            r_out_word <= done.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- bench/btpl_lookup_checker.sv -----
`timescale 1ns / 100ps
// checker: mirrors the trie and registers, predicts each lookup and compares result words
module btpl_lookup_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  btpl_pkg::t_in_word                i_in_word,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  btpl_pkg::t_out_word               i_out_word,
    input  logic                              i_cfg_we,
    input  logic [btpl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [btpl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    import btpl_pkg::*;

    t_node              trie_nodes [int unsigned];
    logic [COUNT_W-1:0] node_count;
    logic [IDX_W-1:0]   v4_root;
    t_out_word          pending_matches [$];
    t_out_word          want;

    initial begin
        o_errors   = 0;
        o_pending  = 0;
        node_count = '0;
        v4_root    = '0;
    end

    function automatic t_out_word longest_match(input t_in_word w);
        logic [IDX_W-1:0] node;
        logic [NET_W-1:0] best;
        t_node            cur;
        t_out_word        res;
        int               span;
        int               pos;
        logic             bit_val;
        node = (w.command == CMD_V4) ? v4_root : '0;
        span = (w.command == CMD_V4) ? V4_W : ADDR_W;
        best = NO_NET;
        res  = '0;
        // pos counts the address bits consumed before reaching node
        for (pos = 0; pos <= span; pos++) begin
            if ({1'b0, node} >= node_count) begin
                res.range_fault = 1'b1;
                return res;
            end
            cur = trie_nodes.exists(node) ? trie_nodes[node] : '0;
            if (!cur.network[NET_W-1])
                best = cur.network;
            if (pos == span)
                break;
            if (w.command == CMD_V4)
                bit_val = w.address_low[V4_W-1-pos];
            else if (pos < 64)
                bit_val = w.address_high[63-pos];
            else
                bit_val = w.address_low[ADDR_W-1-pos];
            node = bit_val ? cur.child_one : cur.child_zero;
            if (node == '0)
                break;
        end
        if (!best[NET_W-1]) begin
            res.found         = 1'b1;
            res.network_index = best[NET_IDX_W-1:0];
        end
        return res;
    endfunction

    task automatic report_field(input string field, input logic [NET_IDX_W-1:0] exp_v,
                                input logic [NET_IDX_W-1:0] got_v);
        o_errors++;
        $display("%0t: result %s mismatch, expected %0h actual %0h", $time, field, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            node_count = '0;
            v4_root    = '0;
            pending_matches.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NODE_COUNT: node_count = i_cfg_data;
                    CFG_IPV4_ROOT:  v4_root = i_cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_in_word.command) inside
                    CMD_WRITE: trie_nodes[i_in_word.node_index] = '{
                        child_one:  i_in_word.child_one,
                        child_zero: i_in_word.child_zero,
                        network:    i_in_word.network_word};
                    CMD_V4, CMD_V6: pending_matches.push_back(longest_match(i_in_word));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_matches.size() == 0) begin
                    o_errors++;
                    $display("%0t: result word %0h with no lookup pending, expected none",
                             $time, i_out_word);
                end else begin
                    want = pending_matches.pop_front();
                    if (i_out_word.found !== want.found)
                        report_field("found", NET_IDX_W'(want.found),
                                     NET_IDX_W'(i_out_word.found));
                    if (i_out_word.network_index !== want.network_index)
                        report_field("network_index", want.network_index,
                                     i_out_word.network_index);
                    if (i_out_word.range_fault !== want.range_fault)
                        report_field("range_fault", NET_IDX_W'(want.range_fault),
                                     NET_IDX_W'(i_out_word.range_fault));
                end
            end
        end
        o_pending = pending_matches.size();
    end

endmodule

// ----- bench/tb_binary_trie_prefix_lookup_top.sv -----
`timescale 1ns / 100ps
// testbench top: clock, reset, trie loading and lookup stimulus, output stalls and verdict
module tb_binary_trie_prefix_lookup_top;
    import btpl_pkg::*;

    localparam int LATENCY_TAIL   = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_INDEX      = 2**IDX_W - 1;
    localparam int ROOT_FROM_POOL = -1;
    localparam int PRESS_NONE     = 0;
    localparam int PRESS_HOLD     = 1;
    localparam int PRESS_PAUSE    = 2;
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_NODE_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int lookup_errors;
    int lookups_pending;

    int idle_pct     = 0;
    int stall_pct    = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int cur_count    = 0;
    int zero_pct     = 0;
    int fault_pct    = 0;
    // nodes that lookups of the current phase may reach, all written at phase start
    logic [IDX_W-1:0] pool [$];

    binary_trie_prefix_lookup_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    btpl_lookup_checker u_lookup_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (lookup_errors),
        .o_pending   (lookups_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_binary_trie_prefix_lookup_top: errors");
            $finish;
        end
    end

    function automatic t_in_word random_word();
        t_in_word w;
        w.command      = 2'($urandom);
        w.node_index   = IDX_W'($urandom);
        w.child_zero   = IDX_W'($urandom);
        w.child_one    = IDX_W'($urandom);
        w.network_word = $urandom;
        w.address_high = {$urandom, $urandom};
        w.address_low  = {$urandom, $urandom};
        return w;
    endfunction

    function automatic t_in_word node_word(input logic [IDX_W-1:0] idx, c0, c1,
                                           input logic [NET_W-1:0] net);
        t_in_word w;
        w            = random_word();
        w.command    = CMD_WRITE;
        w.node_index = idx;
        w.child_zero = c0;
        w.child_one  = c1;
        w.network_word = net;
        return w;
    endfunction

    function automatic t_in_word lookup_word(input logic [1:0] cmd, input logic [63:0] hi, lo);
        t_in_word w;
        w              = random_word();
        w.command      = cmd;
        w.address_high = hi;
        w.address_low  = lo;
        return w;
    endfunction

    // child is 0, a node at or above the count (faults before any read), or a pool node
    function automatic logic [IDX_W-1:0] pick_child();
        int r;
        r = $urandom_range(99);
        if (r < zero_pct)
            return '0;
        if (r < zero_pct + fault_pct && cur_count <= MAX_INDEX)
            return IDX_W'($urandom_range(MAX_INDEX, cur_count));
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_quiet(input int extra);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (lookups_pending != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic configure(input int count, input int root);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_NODE_COUNT;
        i_cfg_data  <= CFG_DATA_W'(count);
        @(negedge i_clk);
        i_cfg_index <= CFG_IPV4_ROOT;
        i_cfg_data  <= CFG_DATA_W'(root);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_count    = count;
    endtask

    task automatic run_phase(input int count, root, zp, fp, send_idle, recv_stall, items,
                             pressure);
        int  root_sel;
        int  done;
        int  r;
        bit  pressed;
        t_in_word w;
        wait_quiet(LATENCY_TAIL);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        zero_pct  = zp;
        fault_pct = fp;
        cur_count = count;
        pool.delete();
        pool.push_back('0);
        if (count > 1) begin
            pool.push_back(IDX_W'(count - 1));
            repeat ($urandom_range(40, 2)) pool.push_back(IDX_W'($urandom_range(count - 1)));
        end
        if (root == ROOT_FROM_POOL) begin
            root_sel = pool[$urandom_range(pool.size() - 1)];
        end else begin
            root_sel = root;
            if (root < count)
                pool.push_back(IDX_W'(root));
        end
        configure(count, root_sel);
        foreach (pool[k])
            send_word(node_word(pool[k], pick_child(), pick_child(), $urandom));
        done    = 0;
        pressed = 1'b0;
        while (done < items) begin
            if (!pressed && done >= items / 2) begin
                pressed = 1'b1;
                if (pressure == PRESS_HOLD)
                    hold_req = 1'b1;
                else if (pressure == PRESS_PAUSE)
                    wait_quiet(0);
            end
            r = $urandom_range(99);
            if (r < 70) begin
                send_word(lookup_word($urandom_range(1) ? CMD_V6 : CMD_V4,
                                      {$urandom, $urandom}, {$urandom, $urandom}));
                done++;
            end else if (r < 85) begin
                send_word(node_word(pool[$urandom_range(pool.size() - 1)], pick_child(),
                                    pick_child(), $urandom));
                done++;
            end else if (r < 95) begin
                // node at a random index, which may lie outside the pool, written with children from pick_child
                send_word(node_word(IDX_W'($urandom), pick_child(), pick_child(), $urandom));
                done++;
            end else begin
                w         = random_word();
                w.command = CMD_IGNORED;
                send_word(w);
            end
        end
    endtask

    initial begin
        t_in_word w;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // small fixed trie: node 1 loops on itself, node 2 loops on zero bits
        configure(64, 2);
        send_word(node_word(18'd0, 18'd1, 18'd3, 32'h8000_0000));
        send_word(node_word(18'd1, 18'd1, 18'd1, 32'h7FFF_FFFF));
        send_word(node_word(18'd3, 18'd0, 18'd64, 32'h0000_0000));
        send_word(node_word(18'd2, 18'd2, 18'd4, 32'hFFFF_FFFF));
        send_word(node_word(18'd4, 18'd0, IDX_W'(MAX_INDEX), 32'h1234_5678));
        send_word(lookup_word(CMD_V6, '0, '0));
        send_word(lookup_word(CMD_V6, '1, '1));
        send_word(lookup_word(CMD_V6, 64'h8000_0000_0000_0000, '0));
        send_word(lookup_word(CMD_V6, '0, '1));
        send_word(lookup_word(CMD_V4, '1, '0));
        send_word(lookup_word(CMD_V4, '0, 64'hFFFF_FFFF_0000_0000));
        send_word(lookup_word(CMD_V4, '0, 64'h0000_0000_8000_0000));
        send_word(lookup_word(CMD_V4, '1, '1));
        send_word(lookup_word(CMD_V4, '0, 64'h0000_0000_7FFF_FFFF));
        w         = '1;
        w.command = CMD_IGNORED;
        send_word(w);

        // ipv4 root outside the node count faults at the first node
        wait_quiet(LATENCY_TAIL);
        configure(64, 70);
        send_word(lookup_word(CMD_V4, '0, '0));
        send_word(lookup_word(CMD_V6, '0, '0));

        // empty table: every lookup faults
        wait_quiet(LATENCY_TAIL);
        configure(0, 0);
        send_word(lookup_word(CMD_V6, '0, '0));
        send_word(lookup_word(CMD_V4, '0, '0));

        run_phase(262144, MAX_INDEX, 10, 0, 0, 0, 160, PRESS_HOLD);
        run_phase(1000, ROOT_FROM_POOL, 12, 6, 73, 0, 150, PRESS_NONE);
        run_phase(40, ROOT_FROM_POOL, 0, 0, 0, 73, 110, PRESS_NONE);
        run_phase(0, 0, 20, 20, 20, 20, 60, PRESS_NONE);
        run_phase(5000, ROOT_FROM_POOL, 25, 10, 20, 20, 170, PRESS_HOLD);
        run_phase(2, 100, 30, 20, 73, 73, 120, PRESS_PAUSE);

        wait_quiet(LATENCY_TAIL);
        if (lookup_errors == 0 && lookups_pending == 0)
            $display("tb_binary_trie_prefix_lookup_top: clean");
        else
            $display("tb_binary_trie_prefix_lookup_top: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/btpl_pkg.sv
rtl/core/btpl_node_mem.sv
rtl/core/btpl_walker.sv
rtl/core/binary_trie_prefix_lookup_top.sv
bench/btpl_lookup_checker.sv
bench/tb_binary_trie_prefix_lookup_top.sv
